// File: rtl/core/ugbb_pkg.sv
// ----------------------------------------------------------------------------
// ugbb_pkg: shared types and constants for the uniform grid box binning block
// Grid sizes, field widths, register indexes, result codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ugbb_pkg;

  // Grid geometry and list sizes
  localparam int GRID_X     = 8;
  localparam int GRID_Y     = 8;
  localparam int CELL_SLOTS = 16;
  localparam int COLLIDERS  = 256;
  localparam int MAX_OUT    = 64;
  localparam int NCELLS     = GRID_X * GRID_Y;

  // Internal widths derived from the geometry
  localparam int XW     = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int YW     = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int IDX_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int CNT_W  = $clog2(CELL_SLOTS + 1);
  localparam int LSLOT_W = $clog2(CELL_SLOTS);
  localparam int MEM_AW = IDX_W + LSLOT_W;
  localparam int N_W    = $clog2(MAX_OUT);
  localparam int ID_W   = (COLLIDERS > 1) ? $clog2(COLLIDERS) : 1;

  // Fixed field widths of the interface
  localparam int COORD_W    = 16;
  localparam int LEN_W      = 15;
  localparam int CELLS_W    = 4;
  localparam int CIDX_W     = 6;
  localparam int SLOT_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  // Divider: 17-bit signed difference, 16-bit magnitude, 17-bit signed quotient
  localparam int DIFF_W = COORD_W + 1;
  localparam int MAG_W  = COORD_W;
  localparam int Q_W    = COORD_W + 1;
  localparam int STEP_W = $clog2(MAG_W);

  // Box corner order (also the order of the corners in tdata)
  localparam logic [1:0] BOX_MIN_X = 2'd0;
  localparam logic [1:0] BOX_MIN_Y = 2'd1;
  localparam logic [1:0] BOX_MAX_X = 2'd2;
  localparam logic [1:0] BOX_MAX_Y = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_MIN_X = 3'd0,
    CFG_GRID_MIN_Y = 3'd1,
    CFG_CELL_LEN_X = 3'd2,
    CFG_CELL_LEN_Y = 3'd3,
    CFG_CELLS_X    = 3'd4,
    CFG_CELLS_Y    = 3'd5
  } cfg_idx_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    RES_STORED  = 2'd0,
    RES_FULL    = 2'd1,
    RES_NONE    = 2'd2,
    RES_CLEARED = 2'd3
  } res_status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DIV_LD,
    S_DIV_RUN,
    S_DIV_ST,
    S_CHECK,
    S_EMPTY,
    S_RD,
    S_WR
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture the accepted request
    logic div_load;    // load divider with the current corner
    logic div_step;    // one restoring-division step
    logic div_store;   // store signed quotient, move to next corner
    logic visit_start; // load cell walk from the clamped ranges
    logic emit_clear;  // clear lists and post the cleared result
    logic emit_empty;  // post the no-cell result
    logic emit_cell;   // update the current cell, post result, advance
  } ugbb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;   // divider is on its final step
    logic op_last;    // current corner is the last one
    logic empty;      // clamped range covers no cell
    logic cell_last;  // current cell is the final one of the walk
    logic out_free;   // output register can take a result
  } ugbb_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ugbb_ram.sv
// ----------------------------------------------------------------------------
// ugbb_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ugbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/ugbb_ctrl.sv
// ----------------------------------------------------------------------------
// ugbb_ctrl: request sequencer for the grid binning block
// Steps each insert request through four corner divisions, the range check and
// the cell walk, and posts results into the datapath output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ugbb_ctrl
  import ugbb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_clear_i,
  output logic           in_ready_o,
  input  wire ugbb_sts_t sts_i,
  output ugbb_cmd_t      cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = in_clear_i ? S_CLEAR : S_DIV_LD;
        end
      end
      S_CLEAR: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_DIV_LD:  state_d = S_DIV_RUN;
      S_DIV_RUN: begin
        if (sts_i.div_done) state_d = S_DIV_ST;
      end
      S_DIV_ST:  state_d = sts_i.op_last ? S_CHECK : S_DIV_LD;
      S_CHECK:   state_d = sts_i.empty ? S_EMPTY : S_RD;
      S_EMPTY: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_RD:      state_d = S_WR;
      S_WR: begin
        if (sts_i.out_free) state_d = sts_i.cell_last ? S_IDLE : S_RD;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CLEAR:   cmd_o.emit_clear  = sts_i.out_free;
      S_DIV_LD:  cmd_o.div_load    = 1'b1;
      S_DIV_RUN: cmd_o.div_step    = 1'b1;
      S_DIV_ST:  cmd_o.div_store   = 1'b1;
      S_CHECK:   cmd_o.visit_start = !sts_i.empty;
      S_EMPTY:   cmd_o.emit_empty  = sts_i.out_free;
      S_RD:      ;
      S_WR:      cmd_o.emit_cell   = sts_i.out_free;
      default:   ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/ugbb_dp.sv
// ----------------------------------------------------------------------------
// ugbb_dp: datapath of the grid binning block
// Configuration registers, shared bit-serial divider, range clamp, cell walk
// counters, per-cell count and member stores, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ugbb_dp
  import ugbb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // request payload
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  // controller link
  input  wire ugbb_cmd_t             cmd_i,
  output ugbb_sts_t                  sts_o,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [CIDX_W-1:0]          out_idx_o,
  output logic [SLOT_W-1:0]          out_slot_o,
  output res_status_e                out_status_o,
  output logic                       out_last_o
);

  // configuration registers
  logic signed [COORD_W-1:0] grid_min_x_q, grid_min_y_q;
  logic [LEN_W-1:0]          len_x_q, len_y_q;
  logic [CELLS_W-1:0]        cells_x_q, cells_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_min_x_q <= '0;
      grid_min_y_q <= '0;
      len_x_q      <= LEN_W'(500);
      len_y_q      <= LEN_W'(500);
      cells_x_q    <= CELLS_W'(8);
      cells_y_q    <= CELLS_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_MIN_X: grid_min_x_q <= cfg_data_i;
        CFG_GRID_MIN_Y: grid_min_y_q <= cfg_data_i;
        CFG_CELL_LEN_X: len_x_q      <= cfg_data_i[LEN_W-1:0];
        CFG_CELL_LEN_Y: len_y_q      <= cfg_data_i[LEN_W-1:0];
        CFG_CELLS_X:    cells_x_q    <= cfg_data_i[CELLS_W-1:0];
        CFG_CELLS_Y:    cells_y_q    <= cfg_data_i[CELLS_W-1:0];
        default:        ;
      endcase
    end
  end

  // columns and rows in use, saturated to the grid
  logic [CELLS_W-1:0] nx, ny;
  assign nx = (int'(cells_x_q) > GRID_X) ? CELLS_W'(GRID_X) : cells_x_q;
  assign ny = (int'(cells_y_q) > GRID_Y) ? CELLS_W'(GRID_Y) : cells_y_q;

  // request capture
  logic [ID_W-1:0]    id_q;
  logic [COORD_W-1:0] box_q [4];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q <= in_data_i[ID_W-1:0];
      for (int i = 0; i < 4; i++) begin
        box_q[i] <= in_data_i[8 + i*COORD_W +: COORD_W];
      end
    end
  end

  // divider operand for the current corner; odd corners are y
  logic [1:0]                op_q;
  logic signed [COORD_W-1:0] coord, origin;
  logic [LEN_W-1:0]          len_raw, den;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_abs;

  always_comb begin
    coord    = box_q[op_q];
    origin   = op_q[0] ? grid_min_y_q : grid_min_x_q;
    len_raw  = op_q[0] ? len_y_q : len_x_q;
    den      = (len_raw == '0) ? LEN_W'(1) : len_raw;
    diff     = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  // restoring divider, one quotient bit per step; quotient shifts into num_q
  logic [MAG_W-1:0]  num_q;
  logic [LEN_W-1:0]  rem_q;
  logic [LEN_W-1:0]  den_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic [LEN_W:0]    rem_sh;
  logic              sub_ok;

  assign rem_sh = {rem_q, num_q[MAG_W-1]};
  assign sub_ok = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      num_q  <= diff_abs[MAG_W-1:0];
      rem_q  <= '0;
      den_q  <= den;
      neg_q  <= diff[DIFF_W-1];
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      if (sub_ok) begin
        rem_q <= LEN_W'(rem_sh - {1'b0, den_q});
      end else begin
        rem_q <= rem_sh[LEN_W-1:0];
      end
      num_q  <= {num_q[MAG_W-2:0], sub_ok};
      step_q <= step_q + STEP_W'(1);
    end
  end

  // signed quotients per corner
  logic signed [Q_W-1:0] q_q [4];
  logic signed [Q_W-1:0] q_pos;
  assign q_pos = signed'({1'b0, num_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      q_q[op_q] <= neg_q ? -q_pos : q_pos;
    end
  end

  // corner counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= BOX_MIN_X;
    end else if (cmd_i.load) begin
      op_q <= BOX_MIN_X;
    end else if (cmd_i.div_store) begin
      op_q <= op_q + 2'd1;
    end
  end

  // clamp ranges to the grid in use
  logic signed [Q_W-1:0] nx_m1, ny_m1, x0c, y0c, x1c, y1c;
  logic                  empty;

  always_comb begin
    nx_m1 = signed'({{(Q_W-CELLS_W){1'b0}}, nx}) - Q_W'(1);
    ny_m1 = signed'({{(Q_W-CELLS_W){1'b0}}, ny}) - Q_W'(1);
    x0c   = q_q[BOX_MIN_X][Q_W-1] ? '0 : q_q[BOX_MIN_X];
    y0c   = q_q[BOX_MIN_Y][Q_W-1] ? '0 : q_q[BOX_MIN_Y];
    x1c   = (q_q[BOX_MAX_X] > nx_m1) ? nx_m1 : q_q[BOX_MAX_X];
    y1c   = (q_q[BOX_MAX_Y] > ny_m1) ? ny_m1 : q_q[BOX_MAX_Y];
    empty = (x0c > x1c) || (y0c > y1c);
  end

  // cell walk: row by row, lowest column first
  logic [XW-1:0]  x0n_q, x1n_q, cur_x_q;
  logic [YW-1:0]  y1n_q, cur_y_q;
  logic [N_W-1:0] n_q;
  logic           cell_last;

  assign cell_last = ((cur_x_q == x1n_q) && (cur_y_q == y1n_q))
                     || (n_q == N_W'(MAX_OUT - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.visit_start) begin
      x0n_q   <= x0c[XW-1:0];
      x1n_q   <= x1c[XW-1:0];
      y1n_q   <= y1c[YW-1:0];
      cur_x_q <= x0c[XW-1:0];
      cur_y_q <= y0c[YW-1:0];
      n_q     <= '0;
    end else if (cmd_i.emit_cell) begin
      n_q <= n_q + N_W'(1);
      if (cur_x_q == x1n_q) begin
        cur_x_q <= x0n_q;
        cur_y_q <= cur_y_q + YW'(1);
      end else begin
        cur_x_q <= cur_x_q + XW'(1);
      end
    end
  end

  // linear index of the current cell
  logic [YW+CELLS_W-1:0] row_base;
  logic [IDX_W-1:0]      idx;
  assign row_base = {{CELLS_W{1'b0}}, cur_y_q} * {{YW{1'b0}}, nx};
  assign idx      = IDX_W'(row_base + (YW+CELLS_W)'(cur_x_q));

  // per-cell counts: RAM plus a valid bit per cell that reads as zero
  logic [NCELLS-1:0] cnt_vld_q;
  logic [CNT_W-1:0]  cnt_rdata, cnt;
  logic              full;
  logic              cnt_we;

  assign cnt    = cnt_vld_q[idx] ? cnt_rdata : '0;
  assign full   = (int'(cnt) >= CELL_SLOTS);
  assign cnt_we = cmd_i.emit_cell && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.emit_clear) begin
      cnt_vld_q <= '0;
    end else if (cnt_we) begin
      cnt_vld_q[idx] <= 1'b1;
    end
  end

  ugbb_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NCELLS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (idx),
    .wdata_i (cnt + CNT_W'(1)),
    .raddr_i (idx),
    .rdata_o (cnt_rdata)
  );

  // occupant lists, write only
  logic [MEM_AW-1:0] mem_addr;
  assign mem_addr = {idx, cnt[LSLOT_W-1:0]};

  ugbb_ram #(
    .WIDTH (ID_W),
    .DEPTH (NCELLS * CELL_SLOTS)
  ) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (mem_addr),
    .wdata_i (id_q),
    .raddr_i (mem_addr),
    .rdata_o ()
  );

  // output register
  logic        out_valid_q;
  logic        out_free;
  logic        emit_any;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit_any = cmd_i.emit_clear || cmd_i.emit_empty || cmd_i.emit_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_any) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_cell) begin
      out_idx_o    <= CIDX_W'(idx);
      out_slot_o   <= full ? '0 : SLOT_W'(cnt);
      out_status_o <= full ? RES_FULL : RES_STORED;
      out_last_o   <= cell_last;
    end else if (cmd_i.emit_clear || cmd_i.emit_empty) begin
      out_idx_o    <= '0;
      out_slot_o   <= '0;
      out_status_o <= cmd_i.emit_clear ? RES_CLEARED : RES_NONE;
      out_last_o   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  // status to controller
  always_comb begin
    sts_o           = '0;
    sts_o.div_done  = (step_q == STEP_W'(MAG_W - 1));
    sts_o.op_last   = (op_q == BOX_MAX_Y);
    sts_o.empty     = empty;
    sts_o.cell_last = cell_last;
    sts_o.out_free  = out_free;
  end

endmodule

`default_nettype wire

// File: rtl/core/uniform_grid_box_binning.sv
// ----------------------------------------------------------------------------
// uniform_grid_box_binning: 2D uniform grid broad-phase binning
// Maps a collider box to grid cells and appends the id to each covered cell's
// occupant list that has a free slot; a clear request empties all lists.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------
//   s_axis   | in  | s_axis_tvalid/tready   | tuser req_type, tdata box + id
//   m_axis   | out | m_axis_tvalid/tready   | tdata idx/slot, tuser status,
//            |     |                        | tlast last result of request
//   cfg      | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Every request is taken in the idle state. An insert then runs the four corner
// divisions (one shared restoring divider, one quotient bit per cycle), each as
// load, run and store, then the range check, then for each covered cell a count
// RAM read and then its update, or posts the no-cell result. A clear posts its
// result once the output register is free.
// The count store clears via per-cell valid bits, at reset too.
// A stalled output holds the walk; one request is in flight at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module uniform_grid_box_binning
  import ugbb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // requests
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // collider_id[7:0], box_min_x[23:8], box_min_y[39:24],
  // box_max_x[55:40], box_max_y[71:56]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[0]
  input  wire logic                  s_axis_tuser,
  // results
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // cell_index[5:0], slot[9:6], zero fill[15:10]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]        m_axis_tuser,
  output logic                       m_axis_tlast
);

  ugbb_cmd_t   cmd;
  ugbb_sts_t   sts;
  logic        in_ready;
  logic [CIDX_W-1:0] out_idx;
  logic [SLOT_W-1:0] out_slot;
  res_status_e out_status;

  // request sequencer
  ugbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_clear_i (s_axis_tuser),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  ugbb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_idx_o    (out_idx),
    .out_slot_o   (out_slot),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  // result packing
  assign s_axis_tready = in_ready;
  assign m_axis_tdata  = {{(OUT_DATA_W-CIDX_W-SLOT_W){1'b0}}, out_slot, out_idx};
  assign m_axis_tuser  = out_status;

endmodule

`default_nettype wire
